// File: src/quaternion_to_euler_angles_assert.svh
// Assertion macros for the quaternion to Euler angle RTL.
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// Check cond at every edge in which ante holds.
`define QTE_ASSERT_IMPLIES(lbl, ante, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cond)) \
        else $error(msg);

// Check cond in the cycle after ante holds.
`define QTE_ASSERT_NEXT(lbl, ante, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cond)) \
        else $error(msg);

`endif

// File: src/qte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_pkg
// Shared constants, types and the arctangent table of the Euler angle pipe.
// ----------------------------------------------------------------------------
package qte_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int ANG_TABLE_LEN = 24;
    localparam int NSTEPS = (CORDIC_STEPS > ANG_TABLE_LEN) ? ANG_TABLE_LEN :
                            ((CORDIC_STEPS < 0) ? 0 : CORDIC_STEPS);

    localparam int TERM_W = 32;
    localparam int CW = 36;   // CORDIC x/y width, room for pre-rotation and gain
    localparam int ZW = 34;   // angle accumulator, centidegrees with 16 fraction bits
    localparam int ROOT_W = 29;

    localparam int TERMS_LAT = 2;
    localparam int ISQRT_LAT = 1 + ROOT_W;
    localparam int CORDIC_LAT = NSTEPS + 2;
    localparam int LAT = TERMS_LAT + ISQRT_LAT + CORDIC_LAT;

    localparam logic signed [ZW-1:0] QUARTER_TURN = ZW'(589824000);
    localparam logic signed [15:0] LIMIT_FULL = 16'sd18000;
    localparam logic signed [15:0] LIMIT_HALF = 16'sd9000;

    typedef struct packed {
        logic signed [TERM_W-1:0] sinr;
        logic signed [TERM_W-1:0] cosr;
        logic signed [TERM_W-1:0] sinp;
        logic signed [TERM_W-1:0] siny;
        logic signed [TERM_W-1:0] cosy;
    } t_terms;

    function automatic logic signed [ZW-1:0] ang_entry(input int idx);
        logic [29:0] v;
        unique case (idx)
            0:  v = 30'd294912000;
            1:  v = 30'd174096719;
            2:  v = 30'd91987925;
            3:  v = 30'd46694507;
            4:  v = 30'd23437865;
            5:  v = 30'd11730358;
            6:  v = 30'd5866610;
            7:  v = 30'd2933484;
            8:  v = 30'd1466764;
            9:  v = 30'd733385;
            10: v = 30'd366693;
            11: v = 30'd183346;
            12: v = 30'd91673;
            13: v = 30'd45837;
            14: v = 30'd22918;
            15: v = 30'd11459;
            16: v = 30'd5730;
            17: v = 30'd2865;
            18: v = 30'd1432;
            19: v = 30'd716;
            20: v = 30'd358;
            21: v = 30'd179;
            22: v = 30'd90;
            23: v = 30'd45;
            default: v = 30'd0;
        endcase
        return ZW'(v);
    endfunction

endpackage

// File: src/qte_terms.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_terms
// Two stages: the nine quaternion products, then the saturated Q28 terms.
// ----------------------------------------------------------------------------
module qte_terms (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [15:0]  i_w,
    input  logic signed [15:0]  i_x,
    input  logic signed [15:0]  i_y,
    input  logic signed [15:0]  i_z,
    output qte_pkg::t_terms     o_terms
);

    logic signed [31:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    qte_pkg::t_terms    r_terms;
    qte_pkg::t_terms    n_terms;
    logic signed [33:0] sinp_sat;

    // Saturate a 34-bit sum to the 32-bit term range.
    function automatic logic signed [31:0] sat34(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sh0_7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sh0_8000_0000) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wx <= i_w * i_x;
            r_yz <= i_y * i_z;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_wy <= i_w * i_y;
            r_zx <= i_z * i_x;
            r_wz <= i_w * i_z;
            r_xy <= i_x * i_y;
            r_zz <= i_z * i_z;
        end
    end

    always_comb begin
        n_terms.sinr = sat34(34'(r_wx + 34'(r_yz)) <<< 1);
        n_terms.cosr = sat34(34'sd268435456 - ((34'(r_xx) + 34'(r_yy)) <<< 1));
        n_terms.siny = sat34(34'(r_wz + 34'(r_xy)) <<< 1);
        n_terms.cosy = sat34(34'sd268435456 - ((34'(r_yy) + 34'(r_zz)) <<< 1));
        // Clamp the pitch sine to plus or minus one.
        sinp_sat = (34'(r_wy) - 34'(r_zx)) <<< 1;
        if (sinp_sat > 34'sd268435456) begin
            n_terms.sinp = 32'sd268435456;
        end else if (sinp_sat < -34'sd268435456) begin
            n_terms.sinp = -32'sd268435456;
        end else begin
            n_terms.sinp = sinp_sat[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_terms <= n_terms;
        end
    end

    assign o_terms = r_terms;

endmodule

// File: src/qte_isqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_isqrt
// Pitch cosine: square the sine, then a pipelined floor square root of
// 1 - s*s, one root bit per stage. The terms travel alongside.
// ----------------------------------------------------------------------------
module qte_isqrt (
    input  logic                            i_clk,
    input  logic                            i_en,
    input  qte_pkg::t_terms                 i_terms,
    output qte_pkg::t_terms                 o_terms,
    output logic [qte_pkg::ROOT_W-1:0]      o_cosp
);

    localparam int NW = 58;

    logic [59:0]     r_sq;
    qte_pkg::t_terms r_ts;
    logic [NW-1:0]   r_rem  [qte_pkg::ROOT_W];
    logic [NW-1:0]   r_root [qte_pkg::ROOT_W];
    qte_pkg::t_terms r_t    [qte_pkg::ROOT_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= 60'($signed(i_terms.sinp[29:0]) * $signed(i_terms.sinp[29:0]));
            r_ts <= i_terms;
        end
    end

    for (genvar k = 0; k < qte_pkg::ROOT_W; k++) begin : g_step
        localparam logic [NW-1:0] BIT = NW'(1) << (2 * (qte_pkg::ROOT_W - 1 - k));
        logic [NW-1:0]   rem_in, root_in, trial, n_rem, n_root;
        qte_pkg::t_terms t_in;

        if (k == 0) begin : g_first
            assign rem_in  = (NW'(1) << 56) - NW'(r_sq);
            assign root_in = '0;
            assign t_in    = r_ts;
        end else begin : g_next
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign t_in    = r_t[k-1];
        end

        always_comb begin
            trial = root_in + BIT;
            if (rem_in >= trial) begin
                n_rem  = rem_in - trial;
                n_root = (root_in >> 1) + BIT;
            end else begin
                n_rem  = rem_in;
                n_root = root_in >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_t[k]    <= t_in;
            end
        end
    end

    assign o_terms = r_t[qte_pkg::ROOT_W-1];
    assign o_cosp  = r_root[qte_pkg::ROOT_W-1][qte_pkg::ROOT_W-1:0];

endmodule

// File: src/qte_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qte_cordic
// Pipelined four-quadrant arctangent: quadrant pre-rotation, one
// micro-rotation per stage, then rounding to centidegrees and clamping.
// ----------------------------------------------------------------------------
module qte_cordic (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [qte_pkg::TERM_W-1:0]   i_y,
    input  logic signed [qte_pkg::TERM_W-1:0]   i_x,
    input  logic signed [15:0]                  i_limit,
    output logic signed [15:0]                  o_angle
);

    localparam int CW = qte_pkg::CW;
    localparam int ZW = qte_pkg::ZW;
    localparam int N  = qte_pkg::NSTEPS;

    logic signed [CW-1:0] r_x [N+1];
    logic signed [CW-1:0] r_y [N+1];
    logic signed [ZW-1:0] r_z [N+1];
    logic                 r_zero [N+1];
    logic signed [15:0]   r_angle;

    logic signed [CW-1:0] xe, ye;
    logic signed [ZW-1:0] zabs, zrnd;
    logic signed [17:0]   rnd, lim;
    logic signed [15:0]   n_angle;

    assign xe = CW'(i_x);
    assign ye = CW'(i_y);

    // Pre-rotate by a quarter turn when x is negative.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_zero[0] <= (i_x == '0) && (i_y == '0);
            if (i_x < 0) begin
                if (i_y >= 0) begin
                    r_x[0] <= ye;
                    r_y[0] <= -xe;
                    r_z[0] <= qte_pkg::QUARTER_TURN;
                end else begin
                    r_x[0] <= -ye;
                    r_y[0] <= xe;
                    r_z[0] <= -qte_pkg::QUARTER_TURN;
                end
            end else begin
                r_x[0] <= xe;
                r_y[0] <= ye;
                r_z[0] <= '0;
            end
        end
    end

    for (genvar i = 0; i < N; i++) begin : g_rot
        localparam logic signed [ZW-1:0] ANG = qte_pkg::ang_entry(i);
        logic signed [CW-1:0] dx, dy;
        assign dx = r_y[i] >>> i;
        assign dy = r_x[i] >>> i;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_zero[i+1] <= r_zero[i];
                if (r_y[i] >= 0) begin
                    r_x[i+1] <= r_x[i] + dx;
                    r_y[i+1] <= r_y[i] - dy;
                    r_z[i+1] <= r_z[i] + ANG;
                end else begin
                    r_x[i+1] <= r_x[i] - dx;
                    r_y[i+1] <= r_y[i] + dy;
                    r_z[i+1] <= r_z[i] - ANG;
                end
            end
        end
    end

    // Round half away from zero, then clamp to the angle limit.
    always_comb begin
        zabs = (r_z[N] < 0) ? -r_z[N] : r_z[N];
        zrnd = (zabs + ZW'(32768)) >>> 16;
        rnd  = (r_z[N] < 0) ? -zrnd[17:0] : zrnd[17:0];
        lim  = 18'(i_limit);
        if (r_zero[N]) begin
            n_angle = '0;
        end else if (rnd > lim) begin
            n_angle = i_limit;
        end else if (rnd < -lim) begin
            n_angle = -i_limit;
        end else begin
            n_angle = rnd[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

// File: src/quaternion_to_euler_angles.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Q14 quaternion in, ZYX roll / pitch / yaw in rounded centidegrees out.
// ----------------------------------------------------------------------------
// One transaction is accepted per clock while the sink is not stalling.
// Each result passes through the products and saturated terms, the squared
// pitch sine and its one-bit-per-stage square root, then the CORDIC pipe of
// one micro-rotation per stage plus pre-rotation and rounding. Depth is set
// by the square root and the CORDIC stage count. The last stage is the
// output register; when the sink stalls, the whole pipe holds and
// o_s_axis_tready drops, so no transaction is lost or repeated.
module quaternion_to_euler_angles (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [63:0] i_s_axis_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata    // roll_angle, pitch_angle, yaw_angle, pad
);

    localparam int LAT = qte_pkg::LAT;

    logic [LAT-1:0] r_vld;
    logic           en;

    qte_pkg::t_terms                terms_a, terms_b;
    logic [qte_pkg::ROOT_W-1:0]     cosp;
    logic signed [15:0]             roll, pitch, yaw;

    // Advance everything when the output slot is free or being drained.
    assign en              = !r_vld[LAT-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_s_axis_tvalid};
        end
    end

    qte_terms u_terms (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_w     (i_s_axis_tdata[15:0]),
        .i_x     (i_s_axis_tdata[31:16]),
        .i_y     (i_s_axis_tdata[47:32]),
        .i_z     (i_s_axis_tdata[63:48]),
        .o_terms (terms_a)
    );

    qte_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_terms (terms_a),
        .o_terms (terms_b),
        .o_cosp  (cosp)
    );

    qte_cordic u_roll (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (terms_b.sinr),
        .i_x     (terms_b.cosr),
        .i_limit (qte_pkg::LIMIT_FULL),
        .o_angle (roll)
    );

    qte_cordic u_pitch (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (terms_b.sinp),
        .i_x     (qte_pkg::TERM_W'(cosp)),
        .i_limit (qte_pkg::LIMIT_HALF),
        .o_angle (pitch)
    );

    qte_cordic u_yaw (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_y     (terms_b.siny),
        .i_x     (terms_b.cosy),
        .i_limit (qte_pkg::LIMIT_FULL),
        .o_angle (yaw)
    );

    assign o_m_axis_tdata = {1'b0, yaw, pitch[14:0], roll};

`include "quaternion_to_euler_angles_assert.svh"

    `QTE_ASSERT_IMPLIES(a_roll_range, o_m_axis_tvalid,
        (roll <= 16'sd18000) && (roll >= -16'sd18000), "roll out of range")
    `QTE_ASSERT_IMPLIES(a_pitch_range, o_m_axis_tvalid,
        (pitch <= 16'sd9000) && (pitch >= -16'sd9000), "pitch out of range")
    `QTE_ASSERT_IMPLIES(a_yaw_range, o_m_axis_tvalid,
        (yaw <= 16'sd18000) && (yaw >= -16'sd18000), "yaw out of range")
    `QTE_ASSERT_NEXT(a_hold_pipe, o_m_axis_tvalid && !i_m_axis_tready,
        $stable(r_vld), "pipeline moved during stall")

endmodule
